### design/rfa_pkg.sv
// Shared types and constants for the rational fraction ALU.
package rfa_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int MAG_W = 64;  // magnitude of a double-width intermediate
  localparam int CNT_W = 7;   // divider bit counter

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_NEG = 2'd2,
    OP_RCP = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] r_num;
    logic signed [31:0] r_den;
    logic               overflow;
  } rsp_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [1:0]             op;
    logic                   an_neg;
    logic [WORD_WIDTH-1:0]  an_mag;
    logic                   ad_neg;
    logic [WORD_WIDTH-1:0]  ad_mag;
    logic                   bn_neg;
    logic [WORD_WIDTH-1:0]  bn_mag;
    logic                   bd_neg;
    logic [WORD_WIDTH-1:0]  bd_mag;
  } item_t;

  // Sign-magnitude view of the low WORD_WIDTH bits of a field.
  function automatic logic [WORD_WIDTH:0] to_sm(input logic [31:0] raw);
    logic [WORD_WIDTH-1:0] v;
    logic                  neg;
    v   = raw[WORD_WIDTH-1:0];
    neg = v[WORD_WIDTH-1];
    return {neg, neg ? (~v + 1'b1) : v};
  endfunction

  // Encode to a word, sign-extended to 32 bits; bit 32 is overflow.
  function automatic logic [32:0] encode(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0]      lim;
    logic [MAG_W-1:0]      v;
    logic                  ovf;
    logic [WORD_WIDTH-1:0] w;
    lim = MAG_W'(1) << (WORD_WIDTH - 1);
    ovf = neg ? (mag > lim) : (mag >= lim);
    v   = neg ? (MAG_W'(0) - mag) : mag;
    w   = v[WORD_WIDTH-1:0];
    return {ovf, 32'($signed(w))};
  endfunction

endpackage

### design/rfa_front.sv
// Front end: accepts requests, splits operands to sign-magnitude, fills a queue.
module rfa_front import rfa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  req_t  in_data,
  output logic  q_valid,
  input  logic  q_pop,
  output item_t q_data
);

  localparam int QD = 2;

  item_t      mem [QD];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push;
  item_t      cls;
  logic [WORD_WIDTH:0] san, sad, sbn, sbd;

  always_comb begin
    san = to_sm(in_data.a_num);
    sad = to_sm(in_data.a_den);
    sbn = to_sm(in_data.b_num);
    sbd = to_sm(in_data.b_den);
    cls.op     = in_data.req_type;
    cls.an_neg = san[WORD_WIDTH];
    cls.an_mag = san[WORD_WIDTH-1:0];
    cls.ad_neg = sad[WORD_WIDTH];
    cls.ad_mag = sad[WORD_WIDTH-1:0];
    cls.bn_neg = sbn[WORD_WIDTH];
    cls.bn_mag = sbn[WORD_WIDTH-1:0];
    cls.bd_neg = sbd[WORD_WIDTH];
    cls.bd_mag = sbd[WORD_WIDTH-1:0];
  end

  assign in_stall = (cnt == 2'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop && q_valid) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'(QD))
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 && push) |=> q_valid)
    else $error("pushed item not visible");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'(QD) && !(q_pop && q_valid)) |=> in_stall)
    else $error("full queue released stall");

endmodule

### design/rfa_back.sv
// Back end: products, Euclid reduction on a serial divider, result register.
module rfa_back import rfa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  output logic  q_pop,
  input  item_t q_data,
  output logic  out_valid,
  input  logic  out_stall,
  output rsp_t  out_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,
    S_MUL2 = 8'b0000_0100,
    S_SUM  = 8'b0000_1000,
    S_GCD  = 8'b0001_0000,
    S_DIVN = 8'b0010_0000,
    S_DIVD = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } st_t;

  st_t state;
  item_t it;
  logic [MAG_W-1:0] p1, p2;
  logic             p1n, p2n;
  logic [MAG_W-1:0] num, den, n, qacc;
  logic             num_n, den_n, m_n, n_n;
  logic [MAG_W-1:0] rn_mag;
  logic             rn_neg;

  // restoring divider: dividend dq, divisor dv, remainder dr
  logic [MAG_W-1:0] dq, dv, dr;
  logic [CNT_W-1:0] dcnt;
  logic             dbusy;
  logic [MAG_W:0]   trial;
  logic [MAG_W-1:0] dr_sh;

  // shared 32x32 multiplier
  logic [WORD_WIDTH-1:0] mx, my;
  logic [MAG_W-1:0]      prod;

  logic [32:0] e1, e2;

  always_comb begin
    mx = it.an_mag;
    my = it.bd_mag;
    case (state)
      S_MUL1: begin
        mx = it.an_mag;
        my = (it.op == OP_ADD) ? it.bd_mag : it.bn_mag;
      end
      S_MUL2: begin
        mx = it.ad_mag;
        my = (it.op == OP_ADD) ? it.bn_mag : it.bd_mag;
      end
      S_SUM: begin
        mx = it.ad_mag;
        my = it.bd_mag;
      end
      default: begin
        mx = it.an_mag;
        my = it.bd_mag;
      end
    endcase
    prod  = MAG_W'(mx) * MAG_W'(my);
    dr_sh = {dr[MAG_W-2:0], dq[MAG_W-1]};
    trial = {1'b0, dr_sh} - {1'b0, dv};
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dbusy     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      if (dbusy) begin
        dr   <= trial[MAG_W] ? dr_sh : trial[MAG_W-1:0];
        dq   <= {dq[MAG_W-2:0], ~trial[MAG_W]};
        dcnt <= dcnt - 1'b1;
        if (dcnt == CNT_W'(1)) dbusy <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            it <= q_data;
            if (q_data.op == OP_NEG || q_data.op == OP_RCP) state <= S_DONE;
            else state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1    <= prod;
          p1n   <= (prod != '0) &&
                   (it.an_neg ^ ((it.op == OP_ADD) ? it.bd_neg : it.bn_neg));
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2    <= prod;
          p2n   <= (prod != '0) &&
                   (it.ad_neg ^ ((it.op == OP_ADD) ? it.bn_neg : it.bd_neg));
          state <= S_SUM;
        end
        S_SUM: begin
          if (it.op == OP_ADD) begin
            den   <= prod;
            den_n <= (prod != '0) && (it.ad_neg ^ it.bd_neg);
            if (p1n == p2n) begin
              num <= p1 + p2; num_n <= p1n && ((p1 + p2) != '0);
            end else if (p1 >= p2) begin
              num <= p1 - p2; num_n <= p1n && (p1 != p2);
            end else begin
              num <= p2 - p1; num_n <= p2n;
            end
          end else begin
            num <= p1; num_n <= p1n;
            den <= p2; den_n <= p2n;
          end
          state <= S_GCD;
          n     <= '0;
        end
        S_GCD: begin
          if (num == '0) begin
            state <= S_DONE;
          end else if (n == '0) begin
            // first step: (m, n) = (den, num)
            m_n <= den_n;
            n <= num; n_n <= num_n;
            dq <= den; dv <= num; dr <= '0; dcnt <= CNT_W'(MAG_W); dbusy <= 1'b1;
          end else if (!dbusy) begin
            if (dr == '0) begin
              dq <= num; dv <= n; dr <= '0; dcnt <= CNT_W'(MAG_W); dbusy <= 1'b1;
              state <= S_DIVN;
            end else begin
              m_n <= n_n;
              n <= dr; n_n <= m_n;
              dq <= n; dv <= dr; dr <= '0; dcnt <= CNT_W'(MAG_W); dbusy <= 1'b1;
            end
          end
        end
        S_DIVN: begin
          if (!dbusy) begin
            qacc  <= dq;
            dq <= den; dv <= n; dr <= '0; dcnt <= CNT_W'(MAG_W); dbusy <= 1'b1;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (!dbusy) begin
            num   <= qacc;
            num_n <= (qacc != '0) && (num_n ^ n_n);
            den   <= dq;
            den_n <= (dq != '0) && (den_n ^ n_n);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= {e1[31:0], e2[31:0], e1[32] | e2[32]};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    rn_mag = num;
    rn_neg = num_n;
    e2     = encode(den_n, den);
    if (it.op == OP_NEG) begin
      rn_mag = MAG_W'(it.an_mag);
      rn_neg = (it.an_mag != '0) && !it.an_neg;
      e2     = encode(it.ad_neg, MAG_W'(it.ad_mag));
    end else if (it.op == OP_RCP) begin
      rn_mag = MAG_W'(it.ad_mag);
      rn_neg = it.ad_neg;
      e2     = encode(it.an_neg, MAG_W'(it.an_mag));
    end else if (num == '0) begin
      rn_mag = '0;
      rn_neg = 1'b0;
      e2     = encode(1'b0, MAG_W'(1));
    end
    e1 = encode(rn_neg, rn_mag);
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |=> state != S_IDLE)
    else $error("popped item not taken");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVD || state == S_DIVN) |-> n != '0)
    else $error("divide by zero gcd");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");

endmodule

### design/rational_fraction_alu_unit.sv
// Top level of the rational fraction ALU: front classifier, queue, reduction back end.
// Negate and reciprocal go straight from idle to the done state; add and multiply form
// the products, then run each Euclid step and two final divides on the 64-step divider.
// Throughput is one item at a time in the back end; the two-entry queue keeps
// accepting until full while a result waits. rst is synchronous and empties queue and FSM.
module rational_fraction_alu_unit import rfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  logic  q_valid, q_pop;
  item_t q_data;

  rfa_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_data
  );

  rfa_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_data
  );

endmodule

### sim/rational_fraction_alu_checker.sv
// Watches both channels of the fraction ALU, predicts each result and compares it.
`timescale 1ns / 1ps
module rational_fraction_alu_checker import rfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  rsp_t out_data,
  output int   errors,
  output int   pending
);

  localparam logic [63:0] WMASK = (64'd1 << WORD_WIDTH) - 64'd1;

  rsp_t expected_fractions[$];

  function automatic void split(input logic [31:0] raw, output bit neg,
                                output logic [63:0] mag);
    logic [63:0] v;
    v   = 64'(raw) & WMASK;
    neg = v[WORD_WIDTH-1];
    mag = neg ? ((~v + 64'd1) & WMASK) : v;
  endfunction

  function automatic void mul_sm(input bit an, input logic [63:0] am, input bit bn,
                                 input logic [63:0] bm, output bit rn,
                                 output logic [63:0] rm);
    rm = am * bm;
    rn = (rm != 0) ? (an ^ bn) : 1'b0;
  endfunction

  function automatic void add_sm(input bit an, input logic [63:0] am, input bit bn,
                                 input logic [63:0] bm, output bit rn,
                                 output logic [63:0] rm);
    if (an == bn) begin
      rm = am + bm;
      rn = an;
    end else if (am >= bm) begin
      rm = am - bm;
      rn = an;
    end else begin
      rm = bm - am;
      rn = bn;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  // Euclid on magnitudes; the divisor's sign follows the remainder chain.
  function automatic void reduce_sm(input bit nn, input logic [63:0] nm, input bit dn,
                                    input logic [63:0] dm, output bit qn,
                                    output logic [63:0] qm, output bit rdn,
                                    output logic [63:0] rdm);
    bit          m_neg, n_neg, t_neg;
    logic [63:0] m_mag, n_mag, rem;
    if (nm == 0) begin
      qn = 0; qm = 0; rdn = 0; rdm = 1;
      return;
    end
    m_neg = dn; m_mag = dm;
    n_neg = nn; n_mag = nm;
    rem = m_mag % n_mag;
    while (rem != 0) begin
      t_neg = m_neg;
      m_neg = n_neg; m_mag = n_mag;
      n_neg = t_neg; n_mag = rem;
      rem = m_mag % n_mag;
    end
    qm  = nm / n_mag;
    qn  = (qm != 0) ? (nn ^ n_neg) : 1'b0;
    rdm = dm / n_mag;
    rdn = (rdm != 0) ? (dn ^ n_neg) : 1'b0;
  endfunction

  function automatic logic [31:0] to_word(input bit neg, input logic [63:0] mag,
                                          inout logic ovf);
    logic [63:0] lim, v;
    lim = 64'd1 << (WORD_WIDTH - 1);
    if (neg ? (mag > lim) : (mag >= lim)) ovf = 1'b1;
    v = neg ? (64'd0 - mag) : mag;
    v &= WMASK;
    if ((v & lim) != 0) v |= ~WMASK;
    return v[31:0];
  endfunction

  function automatic rsp_t fraction_result(input req_t rq);
    bit          an, ad, bn, bd, p1n, p2n, sn, dn, qn, rdn;
    logic [63:0] am, adm, bm, bdm, p1m, p2m, sm, dm, qm, rdm;
    logic        ovf;
    rsp_t        r;
    split(rq.a_num, an, am);
    split(rq.a_den, ad, adm);
    split(rq.b_num, bn, bm);
    split(rq.b_den, bd, bdm);
    case (op_t'(rq.req_type))
      OP_ADD: begin
        mul_sm(an, am, bd, bdm, p1n, p1m);
        mul_sm(ad, adm, bn, bm, p2n, p2m);
        add_sm(p1n, p1m, p2n, p2m, sn, sm);
        mul_sm(ad, adm, bd, bdm, dn, dm);
        reduce_sm(sn, sm, dn, dm, qn, qm, rdn, rdm);
      end
      OP_MUL: begin
        mul_sm(an, am, bn, bm, sn, sm);
        mul_sm(ad, adm, bd, bdm, dn, dm);
        reduce_sm(sn, sm, dn, dm, qn, qm, rdn, rdm);
      end
      OP_NEG: begin
        qm = am; qn = (am != 0) ? !an : an;
        rdm = adm; rdn = ad;
      end
      default: begin
        qm = adm; qn = ad;
        rdm = am; rdn = an;
      end
    endcase
    ovf = 1'b0;
    r.r_num = to_word(qn, qm, ovf);
    r.r_den = to_word(rdn, rdm, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  assign pending = expected_fractions.size();

  initial errors = 0;

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (in_valid && !in_stall) expected_fractions.push_back(fraction_result(in_data));
      if (out_valid && !out_stall) begin
        if (expected_fractions.size() == 0) begin
          $error("result transfer with no expected result");
          errors++;
        end else begin
          want = expected_fractions.pop_front();
          if (out_data.r_num !== want.r_num) begin
            $error("r_num expected %0d got %0d", want.r_num, out_data.r_num);
            errors++;
          end
          if (out_data.r_den !== want.r_den) begin
            $error("r_den expected %0d got %0d", want.r_den, out_data.r_den);
            errors++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow expected %0d got %0d", want.overflow, out_data.overflow);
            errors++;
          end
        end
      end
    end
  end

endmodule

### sim/rational_fraction_alu_unit_test.sv
// Stimulus and verdict for the rational fraction ALU.
`timescale 1ns / 1ps
module rational_fraction_alu_unit_test;
  import rfa_pkg::*;

  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam int RANDOM_ITEMS = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  int   errors;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rational_fraction_alu_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  rational_fraction_alu_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  initial begin
    #400_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly small values keep Euclid short; extremes and full range mixed in.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return MAXV;
      1: return MINV;
      2: return 32'($signed($urandom_range(2)) - 1);
      3, 4: return $urandom;
      default: return 32'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  task automatic send_fraction(input op_t op, input logic [31:0] an, input logic [31:0] ad,
                               input logic [31:0] bn, input logic [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_phase(input int count);
    op_t op;
    for (int i = 0; i < count; i++) begin
      op = op_t'($urandom_range(3));
      send_fraction(op, pick_value(), pick_value(), pick_value(), pick_value());
    end
    in_valid <= 1'b0;
    // let the checker log the last transfer before pending is read
    @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_fraction(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction(OP_ADD, MAXV, MAXV, MAXV, MAXV);
    send_fraction(OP_ADD, MINV, 32'd1, MINV, 32'd1);
    send_fraction(OP_ADD, 32'd3, 32'd0, 32'd0, 32'd0);
    send_fraction(OP_ADD, 32'd1, 32'd2, -32'sd1, 32'd2);
    send_fraction(OP_ADD, MAXV, 32'd1, 32'd1, MAXV);
    send_fraction(OP_MUL, MINV, 32'd1, MINV, 32'd1);
    send_fraction(OP_MUL, 32'd6, -32'sd4, 32'd1, 32'd1);
    send_fraction(OP_MUL, 32'd0, 32'd0, 32'd5, 32'd7);
    send_fraction(OP_MUL, -32'sd1, MINV, MAXV, -32'sd1);
    send_fraction(OP_MUL, 32'd5, 32'd0, 32'd3, 32'd1);
    send_fraction(OP_NEG, MINV, 32'd1, MAXV, MAXV);
    send_fraction(OP_NEG, 32'd0, -32'sd9, MINV, MINV);
    send_fraction(OP_NEG, MAXV, MINV, 32'd0, 32'd0);
    send_fraction(OP_RCP, 32'd0, 32'd5, 32'hffff_ffff, 32'hffff_ffff);
    send_fraction(OP_RCP, MINV, MAXV, 32'd3, 32'd4);
    send_fraction(OP_RCP, 32'hffff_ffff, 32'd0, 32'd0, 32'd0);
    in_valid <= 1'b0;

    send_idle_pct = 32; recv_stall_pct = 51;
    random_phase(RANDOM_ITEMS / 3);
    // hold off until the pipe drains
    while (pending != 0) @(posedge clk);
    send_idle_pct = 51; recv_stall_pct = 32;
    random_phase(RANDOM_ITEMS / 3);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_phase(RANDOM_ITEMS / 3);

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
